/* hdl/robin_hood_hash_table_assert.svh */
// ----------------------------------------------------------------------------
// Robin Hood hash table assertion macros
// Shared property forms for the table's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ROBIN_HOOD_HASH_TABLE_ASSERT_SVH
`define ROBIN_HOOD_HASH_TABLE_ASSERT_SVH

// same-cycle implication
`define RHH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rhh check failed");

// next-cycle implication
`define RHH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rhh check failed");

`endif

/* hdl/rhh_pkg.sv */
// ----------------------------------------------------------------------------
// rhh_pkg
// Codes, states and control/status bundles of the Robin Hood hash table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhh_pkg;

    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_GET    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic [10:0] FILL_RESET = 11'd768;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_HOME  = 8'b0000_0100,
        S_FRD   = 8'b0000_1000,
        S_FIND  = 8'b0001_0000,
        S_PRD   = 8'b0010_0000,
        S_PLACE = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    typedef struct packed {
        logic load;
        logic clr_step;
        logic rem_step;
        logic probe_init;
        logic step;
        logic hit_write;
        logic place_write;
        logic set_notfound;
        logic set_full;
        logic set_found;
        logic set_repl;
        logic cnt_inc;
        logic cnt_dec;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       rem_done;
        logic       empty;
        logic       shorter;
        logic       tomb;
        logic       match;
        logic       find_last;
        logic       place_last;
        logic       full;
        logic       out_free;
        logic [1:0] kind;
    } stat_t;

endpackage

/* hdl/rhh_ram.sv */
// ----------------------------------------------------------------------------
// rhh_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/rhh_ctrl.sv */
// ----------------------------------------------------------------------------
// rhh_ctrl
// Operation sequencer: clearing pass, home slot, lookup walk, insert walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhh_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  rhh_pkg::stat_t stat,
    output rhh_pkg::cmd_t  cmd
);
    import rhh_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        logic miss;
        cmd        = '0;
        state_next = state_reg;
        miss       = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                if (stat.kind == KIND_NONE)
                begin
                    state_next = S_DONE;
                end
                else if (stat.rem_done)
                begin
                    cmd.probe_init = 1'b1;
                    state_next     = S_FRD;
                end
                else
                begin
                    cmd.rem_step = 1'b1;
                end
            end
            S_FRD:
            begin
                state_next = S_FIND;
            end
            S_FIND:
            begin
                if (stat.empty || stat.shorter)
                begin
                    miss = 1'b1;
                end
                else if (stat.match)
                begin
                    state_next = S_DONE;
                    case (stat.kind)
                        KIND_PUT:
                        begin
                            cmd.hit_write = 1'b1;
                            cmd.set_repl  = 1'b1;
                        end
                        KIND_GET:
                        begin
                            cmd.set_found = 1'b1;
                        end
                        default:
                        begin
                            cmd.hit_write = 1'b1;
                            cmd.cnt_dec   = 1'b1;
                        end
                    endcase
                end
                else if (stat.find_last)
                begin
                    miss = 1'b1;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
                if (miss)
                begin
                    if (stat.kind != KIND_PUT)
                    begin
                        cmd.set_notfound = 1'b1;
                        state_next       = S_DONE;
                    end
                    else if (stat.full)
                    begin
                        cmd.set_full = 1'b1;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        cmd.probe_init = 1'b1;
                        state_next     = S_PRD;
                    end
                end
            end
            S_PRD:
            begin
                state_next = S_PLACE;
            end
            S_PLACE:
            begin
                if (stat.empty || (stat.shorter && stat.tomb))
                begin
                    cmd.place_write = 1'b1;
                    cmd.cnt_inc     = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.place_write = stat.shorter;
                    if (stat.place_last)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

/* hdl/rhh_datapath.sv */
// ----------------------------------------------------------------------------
// rhh_datapath
// Slot memory, probe registers, home remainder unit and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhh_datapath #(
    parameter int SLOTS = 1024
) (
    input  logic           clk,
    input  logic           rst_n,
    input  rhh_pkg::cmd_t  cmd,
    output rhh_pkg::stat_t stat,
    input  logic [1:0]     kind,
    input  logic [31:0]    key,
    input  logic [31:0]    value,
    input  logic           cfg_wen,
    input  logic [10:0]    cfg_wdata,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     status,
    output logic [31:0]    found_value,
    output logic           replaced,
    output logic [10:0]    live_count
);
    import rhh_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int NW    = IDX_W + 2;
    localparam int LW    = (IDX_W > 11) ? IDX_W : 11;
    localparam int EW    = IDX_W + 66;
    localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

    logic [1:0]       kind_reg;
    logic [31:0]      key_reg, val_reg;
    logic [IDX_W:0]   rem_reg;
    logic [4:0]       step_reg;
    logic [IDX_W-1:0] pos_reg, clr_reg;
    logic [NW-1:0]    dist_reg, n_reg;
    logic [IDX_W-1:0] c_home_reg;
    logic [31:0]      c_key_reg, c_val_reg;
    logic [10:0]      cnt_reg, fill_reg;
    logic [1:0]       res_status_reg;
    logic [31:0]      res_found_reg;
    logic             res_repl_reg;
    logic             out_valid_reg;
    logic [1:0]       out_status_reg;
    logic [31:0]      out_found_reg;
    logic             out_repl_reg;
    logic [10:0]      out_count_reg;

    logic [31:0]      h;
    logic [IDX_W:0]   rem_t, rem_next;
    logic [IDX_W-1:0] home_val, pos_next, here;
    logic [IDX_W:0]   here_w;
    logic [EW-1:0]    rd_data, wr_data;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             wr_en;
    logic             d_occ, d_tomb, swap;
    logic [IDX_W-1:0] d_home;
    logic [31:0]      d_key, d_val;
    logic [LW-1:0]    lim, fill_w;

    assign h = (key_reg[30:0] == 31'd0) ? 32'd1 : {1'b0, key_reg[30:0]};

    assign rem_t    = {rem_reg[IDX_W-1:0], h[5'd30 - step_reg]};
    assign rem_next = (rem_t >= (IDX_W+1)'(SLOTS)) ? rem_t - (IDX_W+1)'(SLOTS) : rem_t;
    assign home_val = IS_POW2 ? h[IDX_W-1:0] : rem_reg[IDX_W-1:0];

    assign {d_occ, d_tomb, d_home, d_key, d_val} = rd_data;

    assign pos_next = (pos_reg == IDX_W'(SLOTS - 1)) ? '0 : pos_reg + 1'b1;
    assign here_w   = {1'b0, pos_reg} + (IDX_W+1)'(SLOTS) - {1'b0, d_home};
    assign here     = (pos_reg >= d_home) ? pos_reg - d_home : here_w[IDX_W-1:0];
    assign swap     = cmd.place_write && d_occ && !d_tomb;

    assign fill_w = LW'(fill_reg);
    assign lim    = (fill_w > LW'(SLOTS - 1)) ? LW'(SLOTS - 1) : fill_w;

    assign stat.clr_last   = (clr_reg == IDX_W'(SLOTS - 1));
    assign stat.rem_done   = IS_POW2 || (step_reg == 5'd31);
    assign stat.empty      = !d_occ;
    assign stat.shorter    = (dist_reg > NW'(here));
    assign stat.tomb       = d_tomb;
    assign stat.match      = d_occ && !d_tomb && (d_key == key_reg);
    assign stat.find_last  = (n_reg == NW'(SLOTS - 1));
    assign stat.place_last = (n_reg == NW'(4 * SLOTS - 1));
    assign stat.full       = (LW'(cnt_reg) >= lim);
    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.kind       = kind_reg;

    assign rd_addr = cmd.step ? pos_next : pos_reg;
    assign wr_en   = cmd.clr_step || cmd.hit_write || cmd.place_write;
    assign wr_addr = cmd.clr_step ? clr_reg : pos_reg;

    always_comb
    begin
        if (cmd.clr_step)
        begin
            wr_data = '0;
        end
        else if (cmd.place_write)
        begin
            wr_data = {1'b1, 1'b0, c_home_reg, c_key_reg, c_val_reg};
        end
        else if (kind_reg == KIND_REMOVE)
        begin
            wr_data = {d_occ, 1'b1, d_home, d_key, d_val};
        end
        else
        begin
            wr_data = {d_occ, d_tomb, d_home, d_key, val_reg};
        end
    end

    rhh_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            key_reg  <= key;
            val_reg  <= value;
            rem_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.rem_step)
        begin
            rem_reg  <= rem_next;
            step_reg <= step_reg + 1'b1;
        end

        if (cmd.probe_init)
        begin
            pos_reg    <= home_val;
            dist_reg   <= '0;
            n_reg      <= '0;
            c_home_reg <= home_val;
            c_key_reg  <= key_reg;
            c_val_reg  <= val_reg;
        end
        else
        begin
            if (cmd.step)
            begin
                pos_reg  <= pos_next;
                n_reg    <= n_reg + 1'b1;
                dist_reg <= (swap ? NW'(here) : dist_reg) + 1'b1;
            end
            if (swap)
            begin
                c_home_reg <= d_home;
                c_key_reg  <= d_key;
                c_val_reg  <= d_val;
            end
        end

        if (cmd.load)
        begin
            res_status_reg <= ST_OK;
            res_found_reg  <= '0;
            res_repl_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.set_notfound)
            begin
                res_status_reg <= ST_NOTFOUND;
            end
            if (cmd.set_full)
            begin
                res_status_reg <= ST_FULL;
            end
            if (cmd.set_found)
            begin
                res_found_reg <= d_val;
            end
            if (cmd.set_repl)
            begin
                res_repl_reg <= 1'b1;
            end
        end

        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_found_reg  <= res_found_reg;
            out_repl_reg   <= res_repl_reg;
            out_count_reg  <= cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            cnt_reg       <= '0;
            fill_reg      <= FILL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_wen)
            begin
                fill_reg <= cfg_wdata;
            end
            if (cmd.cnt_inc)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (cmd.cnt_dec && (cnt_reg != 11'd0))
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign found_value = out_found_reg;
    assign replaced    = out_repl_reg;
    assign live_count  = out_count_reg;

endmodule

/* hdl/robin_hood_hash_table.sv */
// Sequence: accept, home slot (a bit-serial remainder when SLOTS is not a power of two),
//   first read, lookup walk one probed slot at a time, an insert walk for a missing put, out.
// One operation at a time: input stalls until the result is loaded for output.
// Rate is set by the single read port of the slot RAM, one slot per cycle.
// Reset: a clearing pass of SLOTS cycles runs after reset; input stalls meanwhile.
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// Fixed-capacity Robin Hood open-addressing key/value table with linear probing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module robin_hood_hash_table #(
    parameter int SLOTS = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] key,
    input  logic [31:0] value,
    input  logic        cfg_wen,
    input  logic [10:0] cfg_wdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] found_value,
    output logic        replaced,
    output logic [10:0] live_count
);
    import rhh_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    rhh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rhh_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .kind        (kind),
        .key         (key),
        .value       (value),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_value (found_value),
        .replaced    (replaced),
        .live_count  (live_count)
    );

`include "robin_hood_hash_table_assert.svh"

    `RHH_ASSERT_NXT(a_busy_after_beat, in_valid && !in_stall, in_stall)
    `RHH_ASSERT_NOW(a_status_code, out_valid, status != 2'd3)
    `RHH_ASSERT_NOW(a_repl_ok, out_valid && replaced, status == ST_OK)
    `RHH_ASSERT_NOW(a_found_ok, out_valid && (found_value != 32'd0), status == ST_OK)

endmodule

/* tb/tb_robin_hood_hash_table.sv */
// ----------------------------------------------------------------------------
// Robin Hood hash table testbench
// Drives put, get, remove and no-op beats with random bursts and gaps and checks each
// result against a behavioral model of the probing table, at several fill limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_robin_hood_hash_table;
    import rhh_pkg::*;

    localparam int NSLOT = 1024;
    localparam logic [31:0] TOMB = 32'h8000_0000;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_value;
        logic        replaced;
        logic [10:0] live_count;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] value;
    logic        cfg_wen;
    logic [10:0] cfg_wdata;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] found_value;
    logic        replaced;
    logic [10:0] live_count;

    logic [31:0] mdl_hash [NSLOT];
    logic [31:0] mdl_key [NSLOT];
    logic [31:0] mdl_val [NSLOT];
    int unsigned mdl_count;
    logic [10:0] mdl_fill;

    answer_t     pending_answers [$];
    logic [31:0] key_pool [$];
    int          mismatches;
    int          results_seen;
    int          items_sent;
    longint      cycles;
    logic        hold_req;
    logic        hold_off;
    int          full_seen;
    int          repl_seen;

    robin_hood_hash_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .key         (key),
        .value       (value),
        .cfg_wen     (cfg_wen),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_value (found_value),
        .replaced    (replaced),
        .live_count  (live_count)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] hash_key(logic [31:0] k);
        logic [31:0] h;
        h = k & ~TOMB;
        return (h == 32'd0) ? 32'd1 : h;
    endfunction

    function automatic int home_slot(logic [31:0] h);
        return int'((h & ~TOMB) % NSLOT);
    endfunction

    function automatic int slot_dist(int p);
        return (p + NSLOT - home_slot(mdl_hash[p])) % NSLOT;
    endfunction

    function automatic int locate_key(logic [31:0] k);
        logic [31:0] h;
        int p;
        int d;
        h = hash_key(k);
        p = home_slot(h);
        d = 0;
        for (int n = 0; n < NSLOT; n++)
        begin
            if (mdl_hash[p] == 32'd0)
                return -1;
            if (d > slot_dist(p))
                return -1;
            if (mdl_hash[p] == h && mdl_key[p] == k)
                return p;
            p = (p + 1) % NSLOT;
            d++;
        end
        return -1;
    endfunction

    function automatic bit insert_new(logic [31:0] h, logic [31:0] k, logic [31:0] v);
        int p;
        int d;
        int here;
        logic [31:0] t;
        p = home_slot(h);
        d = 0;
        for (int n = 0; n < 4 * NSLOT; n++)
        begin
            if (mdl_hash[p] == 32'd0)
            begin
                mdl_hash[p] = h; mdl_key[p] = k; mdl_val[p] = v;
                return 1'b1;
            end
            here = slot_dist(p);
            if (d > here)
            begin
                if ((mdl_hash[p] & TOMB) != 32'd0)
                begin
                    mdl_hash[p] = h; mdl_key[p] = k; mdl_val[p] = v;
                    return 1'b1;
                end
                t = mdl_hash[p]; mdl_hash[p] = h; h = t;
                t = mdl_key[p]; mdl_key[p] = k; k = t;
                t = mdl_val[p]; mdl_val[p] = v; v = t;
                d = here;
            end
            p = (p + 1) % NSLOT;
            d++;
        end
        return 1'b0;
    endfunction

    function automatic answer_t apply_op(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        answer_t a;
        int w;
        int unsigned lim;
        a = '0;
        a.status = ST_OK;
        if (op == KIND_PUT)
        begin
            w = locate_key(k);
            if (w >= 0)
            begin
                mdl_val[w] = v;
                a.replaced = 1'b1;
            end
            else
            begin
                lim = (mdl_fill > NSLOT - 1) ? NSLOT - 1 : mdl_fill;
                if (mdl_count >= lim)
                    a.status = ST_FULL;
                else if (insert_new(hash_key(k), k, v))
                    mdl_count++;
            end
        end
        else if (op == KIND_GET)
        begin
            w = locate_key(k);
            if (w >= 0)
                a.found_value = mdl_val[w];
            else
                a.status = ST_NOTFOUND;
        end
        else if (op == KIND_REMOVE)
        begin
            w = locate_key(k);
            if (w >= 0)
            begin
                mdl_hash[w] = mdl_hash[w] | TOMB;
                if (mdl_count > 0)
                    mdl_count--;
            end
            else
                a.status = ST_NOTFOUND;
        end
        a.live_count = mdl_count[10:0];
        return a;
    endfunction

    task automatic send_op(logic [1:0] op, logic [31:0] k, logic [31:0] v);
        in_valid <= 1'b1;
        kind     <= op;
        key      <= k;
        value    <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_answers.push_back(apply_op(op, k, v));
        items_sent++;
        if (op == KIND_PUT)
            key_pool.push_back(k);
    endtask

    task automatic pause_sender();
        in_valid <= 1'b0;
        repeat ($urandom_range(0, 6))
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20)
            @(posedge clk);
    endtask

    task automatic set_fill(logic [10:0] f);
        cfg_wen   <= 1'b1;
        cfg_wdata <= f;
        @(posedge clk);
        cfg_wen   <= 1'b0;
        mdl_fill = f;
    endtask

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (key_pool.size() != 0 && r < 6)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 8)
            return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 21'd0, 10'($urandom_range(0, 15))};
        return $urandom;
    endfunction

    task automatic random_ops(int n, int put_weight);
        int burst;
        int r;
        logic [1:0] op;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                pause_sender();
                burst = $urandom_range(1, 20);
            end
            burst--;
            r = $urandom_range(0, 99);
            if (r < put_weight)
                op = KIND_PUT;
            else if (r < put_weight + (100 - put_weight) / 2)
                op = KIND_GET;
            else if (r < 98)
                op = KIND_REMOVE;
            else
                op = KIND_NONE;
            send_op(op, pick_key(), $urandom);
        end
    endtask

    task automatic test_directed();
        send_op(KIND_GET, 32'd5, 32'd0);
        send_op(KIND_REMOVE, 32'd5, 32'd0);
        send_op(KIND_PUT, 32'd0, 32'hFFFF_FFFF);
        send_op(KIND_PUT, 32'd1, 32'h0000_0001);
        send_op(KIND_PUT, 32'h8000_0000, 32'hA5A5_A5A5);
        send_op(KIND_PUT, 32'h8000_0001, 32'h5A5A_5A5A);
        send_op(KIND_PUT, 32'hFFFF_FFFF, 32'd0);
        send_op(KIND_PUT, 32'd1024, 32'd7);
        send_op(KIND_PUT, 32'd2048, 32'd8);
        send_op(KIND_GET, 32'd0, 32'd0);
        send_op(KIND_GET, 32'h8000_0001, 32'd0);
        send_op(KIND_GET, 32'd2048, 32'd0);
        send_op(KIND_PUT, 32'd1, 32'h1234_5678);
        send_op(KIND_GET, 32'd1, 32'd0);
        send_op(KIND_REMOVE, 32'd1024, 32'd0);
        send_op(KIND_GET, 32'd1024, 32'd0);
        send_op(KIND_GET, 32'd2048, 32'd0);
        send_op(KIND_PUT, 32'd3072, 32'd9);
        send_op(KIND_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(KIND_REMOVE, 32'h7FFF_FFFF, 32'd0);
        drain();
    endtask

    task automatic test_fill_limits();
        set_fill(11'd0);
        send_op(KIND_PUT, 32'd77, 32'd1);
        send_op(KIND_PUT, 32'd0, 32'd2);
        drain();
        set_fill(11'd1);
        random_ops(150, 60);
        drain();
        set_fill(11'd2047);
        random_ops(200, 50);
        drain();
    endtask

    task automatic test_random_mix();
        set_fill(11'd40);
        random_ops(500, 55);
        drain();
        set_fill(FILL_RESET);
        random_ops(600, 45);
        drain();
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        random_ops(60, 50);
        drain();
    endtask

    task automatic test_high_load();
        set_fill(11'd1024);
        for (int i = 0; i < 200; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                pause_sender();
            send_op(KIND_PUT, $urandom, $urandom);
        end
        random_ops(60, 30);
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = KIND_PUT;
        key = '0;
        value = '0;
        cfg_wen = 1'b0;
        cfg_wdata = '0;
        hold_req = 1'b0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        full_seen = 0;
        repl_seen = 0;
        mdl_count = 0;
        mdl_fill = FILL_RESET;
        for (int i = 0; i < NSLOT; i++)
        begin
            mdl_hash[i] = '0;
            mdl_key[i] = '0;
            mdl_val[i] = '0;
        end
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_limits();
        test_random_mix();
        test_backpressure();
        test_high_load();
        $display("Sent %0d beats, checked %0d results (%0d full, %0d overwrites).",
                 items_sent, results_seen, full_seen, repl_seen);
        $display("Fill limits 0, 1, 40, 768, 1024 and 2047 covered, with a long output hold.");
        if (mismatches == 0 && pending_answers.size() == 0)
            $display("tb_robin_hood_hash_table OK");
        else
            $display("tb_robin_hood_hash_table NOT OK");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b1;
        else if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= (cycles % 23 < 5) ? 1'b1 : ($urandom_range(0, 3) == 0);
    end

    initial
    begin
        hold_off = 1'b0;
        wait (hold_req);
        hold_off = 1'b1;
        repeat (400)
            @(posedge clk);
        hold_off = 1'b0;
    end

    always @(posedge clk)
    begin
        answer_t got;
        answer_t exp;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {status, found_value, replaced, live_count};
            results_seen++;
            if (pending_answers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result beat: %p", got);
            end
            else
            begin
                exp = pending_answers.pop_front();
                if (exp.status == ST_FULL)
                    full_seen++;
                if (exp.replaced)
                    repl_seen++;
                if (got !== exp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %p, got %p", exp, got);
                end
            end
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_robin_hood_hash_table NOT OK");
        $finish;
    end

endmodule

/* robin_hood_hash_table.f */
+incdir+hdl
hdl/rhh_pkg.sv
hdl/rhh_ram.sv
hdl/rhh_ctrl.sv
hdl/rhh_datapath.sv
hdl/robin_hood_hash_table.sv
tb/tb_robin_hood_hash_table.sv
